[rtl/core/jq_pkg.sv]
`default_nettype none

package jq_pkg;

	// Result field widths
	localparam int PCT_BITS   = 7;
	localparam int DIR_BITS   = 2;
	localparam int FAULT_BITS = 3;

	// Full deflection value
	localparam int FULL_SCALE = 100;

	// Config port
	localparam int ADDR_BITS = 5;
	localparam int IDX_BITS  = 3;
	localparam int DATA_BITS = 32;

	// Register indexes (byte address = 4 * index)
	localparam logic [IDX_BITS-1:0] REG_ADC_LOW     = 3'd0;
	localparam logic [IDX_BITS-1:0] REG_MID_CODE    = 3'd1;
	localparam logic [IDX_BITS-1:0] REG_ADC_HIGH    = 3'd2;
	localparam logic [IDX_BITS-1:0] REG_DEAD_BAND   = 3'd3;
	localparam logic [IDX_BITS-1:0] REG_ALARM_LOW   = 3'd4;
	localparam logic [IDX_BITS-1:0] REG_ALARM_HIGH  = 3'd5;
	localparam logic [IDX_BITS-1:0] REG_REVERSE_DIR = 3'd6;

	// Register reset values, before truncation to the converter width
	localparam int RST_ADC_LOW    = 100;
	localparam int RST_MID_CODE   = 512;
	localparam int RST_ADC_HIGH   = 900;
	localparam int RST_DEAD_BAND  = 20;
	localparam int RST_ALARM_LOW  = 20;
	localparam int RST_ALARM_HIGH = 1000;

	typedef enum logic [DIR_BITS-1:0] {
		DIR_STOP = 2'd0,
		DIR_FWD  = 2'd1,
		DIR_BACK = 2'd2
	} dir_t;

	typedef enum logic [FAULT_BITS-1:0] {
		F_OK      = 3'd0,
		F_CAL     = 3'd1,
		F_RANGE   = 3'd2,
		F_ZERO    = 3'd3,
		F_DEADMAN = 3'd4,
		F_ESTOP   = 3'd5
	} fault_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_EVAL = 2'd1,
		ST_DIV  = 2'd2,
		ST_DONE = 2'd3
	} state_t;

endpackage

`default_nettype wire

[rtl/core/joystick_qualifier.sv]
`default_nettype none

// Joystick qualifier: one transaction on the input channel carries a converter
// sample plus the deadman and emergency-stop switch levels; it yields exactly one
// result transaction with direction, percent (0..100), fault code and the
// deadman-armed flag. The armed flag is set when deadman is held while the
// previous result's percent was 0 and cleared when deadman is released. Faults
// are ranked estop, calibration, input range, zero sample, deadman; any fault
// gives stop at 0%. Without a fault the percent is a truncating linear map from
// the dead band edge to adc_low/adc_high, 100 beyond them (a sample exactly at
// adc_low gives stop at 0%), and reverse_dir swaps forward and backward. A
// transaction inside a mapped range goes from acceptance through an evaluation
// state and a restoring divider that produces one quotient bit per cycle, one
// for each bit of the 7-bit percent, to the load of the output register, which
// waits while an untaken result is held. A fault, a stop or a full-scale result
// skips the divider. A new input is accepted as soon as the previous result sits
// in the output register, even if the consumer has not taken it yet. Configuration
// is written over an APB-style port (register i at byte address 4*i, pready tied
// high) and must only be written while the block is idle.
module joystick_qualifier #(
	parameter int ADC_BITS = 10
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// Config port
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire  [jq_pkg::ADDR_BITS-1:0]     paddr,
	input  wire  [jq_pkg::DATA_BITS-1:0]     pwdata,
	output logic [jq_pkg::DATA_BITS-1:0]     prdata,
	output logic                             pready,
	// Input channel
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire  [ADC_BITS-1:0]              sample,
	input  wire                              deadman_held,
	input  wire                              estop_ok,
	// Output channel
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [jq_pkg::DIR_BITS-1:0]      direction,
	output logic [jq_pkg::PCT_BITS-1:0]      percent,
	output logic [jq_pkg::FAULT_BITS-1:0]    fault_code,
	output logic                             deadman_armed
);

	localparam int PB  = jq_pkg::PCT_BITS;
	localparam int WB  = ADC_BITS + 1;          // room for center + dead band
	localparam int DW  = ADC_BITS + PB;         // divider width, num*100 < 2^DW
	localparam int CNT_BITS = $clog2(PB);
	localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(PB - 1);

	localparam logic [ADC_BITS-1:0] RST_ADC_LOW    = ADC_BITS'(jq_pkg::RST_ADC_LOW);
	localparam logic [ADC_BITS-1:0] RST_MID_CODE   = ADC_BITS'(jq_pkg::RST_MID_CODE);
	localparam logic [ADC_BITS-1:0] RST_ADC_HIGH   = ADC_BITS'(jq_pkg::RST_ADC_HIGH);
	localparam logic [ADC_BITS-1:0] RST_DEAD_BAND  = ADC_BITS'(jq_pkg::RST_DEAD_BAND);
	localparam logic [ADC_BITS-1:0] RST_ALARM_LOW  = ADC_BITS'(jq_pkg::RST_ALARM_LOW);
	localparam logic [ADC_BITS-1:0] RST_ALARM_HIGH = ADC_BITS'(jq_pkg::RST_ALARM_HIGH);

	// ------------------------------------------------------------------
	// Config registers
	// ------------------------------------------------------------------
	logic [ADC_BITS-1:0] adc_low_q, mid_code_q, adc_high_q, dead_band_q;
	logic [ADC_BITS-1:0] alarm_low_q, alarm_high_q;
	logic                reverse_dir_q;
	logic                cfg_wr;
	logic [jq_pkg::IDX_BITS-1:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[jq_pkg::ADDR_BITS-1:2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adc_low_q     <= RST_ADC_LOW;
			mid_code_q    <= RST_MID_CODE;
			adc_high_q    <= RST_ADC_HIGH;
			dead_band_q   <= RST_DEAD_BAND;
			alarm_low_q   <= RST_ALARM_LOW;
			alarm_high_q  <= RST_ALARM_HIGH;
			reverse_dir_q <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				jq_pkg::REG_ADC_LOW:     adc_low_q     <= pwdata[ADC_BITS-1:0];
				jq_pkg::REG_MID_CODE:    mid_code_q    <= pwdata[ADC_BITS-1:0];
				jq_pkg::REG_ADC_HIGH:    adc_high_q    <= pwdata[ADC_BITS-1:0];
				jq_pkg::REG_DEAD_BAND:   dead_band_q   <= pwdata[ADC_BITS-1:0];
				jq_pkg::REG_ALARM_LOW:   alarm_low_q   <= pwdata[ADC_BITS-1:0];
				jq_pkg::REG_ALARM_HIGH:  alarm_high_q  <= pwdata[ADC_BITS-1:0];
				jq_pkg::REG_REVERSE_DIR: reverse_dir_q <= pwdata[0];
				default: ;  // unmapped index: dropped
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			jq_pkg::REG_ADC_LOW:     prdata = jq_pkg::DATA_BITS'(adc_low_q);
			jq_pkg::REG_MID_CODE:    prdata = jq_pkg::DATA_BITS'(mid_code_q);
			jq_pkg::REG_ADC_HIGH:    prdata = jq_pkg::DATA_BITS'(adc_high_q);
			jq_pkg::REG_DEAD_BAND:   prdata = jq_pkg::DATA_BITS'(dead_band_q);
			jq_pkg::REG_ALARM_LOW:   prdata = jq_pkg::DATA_BITS'(alarm_low_q);
			jq_pkg::REG_ALARM_HIGH:  prdata = jq_pkg::DATA_BITS'(alarm_high_q);
			jq_pkg::REG_REVERSE_DIR: prdata = jq_pkg::DATA_BITS'(reverse_dir_q);
			default:                 prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Control
	// ------------------------------------------------------------------
	jq_pkg::state_t state_q, state_nxt;
	logic [CNT_BITS-1:0] cnt_q;
	logic in_acc, out_load, ev_div;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			jq_pkg::ST_IDLE: if (in_acc) state_nxt = jq_pkg::ST_EVAL;
			jq_pkg::ST_EVAL: state_nxt = ev_div ? jq_pkg::ST_DIV : jq_pkg::ST_DONE;
			jq_pkg::ST_DIV:  if (cnt_q == CNT_LAST) state_nxt = jq_pkg::ST_DONE;
			jq_pkg::ST_DONE: if (out_load) state_nxt = jq_pkg::ST_IDLE;
			default:         state_nxt = jq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == jq_pkg::ST_IDLE);
		out_load = (state_q == jq_pkg::ST_DONE) && (!out_valid || out_ready);
	end

	assign in_acc = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= jq_pkg::ST_IDLE;
		else         state_q <= state_nxt;
	end

	// ------------------------------------------------------------------
	// Captured transaction and persistent state
	// ------------------------------------------------------------------
	logic [ADC_BITS-1:0] smp_q;
	logic                eok_q;
	logic                armed_q;
	logic [PB-1:0]       last_pct_q;
	logic [PB-1:0]       pct_q;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			smp_q <= sample;
			eok_q <= estop_ok;
		end
	end

	// Armed flag uses the previous result's percent, updated at accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q    <= 1'b0;
			last_pct_q <= '0;
		end else begin
			if (in_acc)
				armed_q <= deadman_held & (armed_q | (last_pct_q == '0));
			if (out_load)
				last_pct_q <= pct_q;
		end
	end

	// ------------------------------------------------------------------
	// Evaluation: fault ranking and mapping case
	// ------------------------------------------------------------------
	logic [WB-1:0] s_w, lo_w, ce_w, hi_w, db_w, al_w, ah_w, upper_w, lower_w;
	logic          cal_ok;
	jq_pkg::fault_t ev_fault;
	jq_pkg::dir_t   ev_dir, dir_map;
	logic [PB-1:0]  ev_pct;
	logic [WB-1:0]  num_w, den_w;

	always_comb begin
		s_w  = WB'(smp_q);
		lo_w = WB'(adc_low_q);
		ce_w = WB'(mid_code_q);
		hi_w = WB'(adc_high_q);
		db_w = WB'(dead_band_q);
		al_w = WB'(alarm_low_q);
		ah_w = WB'(alarm_high_q);
		upper_w = ce_w + db_w;
		lower_w = (ce_w >= db_w) ? (ce_w - db_w) : '0;

		cal_ok = (ah_w > hi_w) && (hi_w > ce_w) && (ce_w > lo_w) && (lo_w > al_w) &&
		         (upper_w < hi_w) && ((lo_w + db_w) < ce_w);

		if (!eok_q)                                   ev_fault = jq_pkg::F_ESTOP;
		else if (!cal_ok)                             ev_fault = jq_pkg::F_CAL;
		else if (s_w > ah_w || s_w < al_w)            ev_fault = jq_pkg::F_RANGE;
		else if (s_w == '0)                           ev_fault = jq_pkg::F_ZERO;
		else if (!armed_q && (s_w > upper_w || s_w < lower_w))
		                                              ev_fault = jq_pkg::F_DEADMAN;
		else                                          ev_fault = jq_pkg::F_OK;

		dir_map = jq_pkg::DIR_STOP;
		ev_pct  = '0;
		ev_div  = 1'b0;
		num_w   = '0;
		den_w   = '0;
		if (ev_fault == jq_pkg::F_OK) begin
			if (s_w > hi_w) begin
				dir_map = jq_pkg::DIR_FWD;
				ev_pct  = PB'(jq_pkg::FULL_SCALE);
			end else if (s_w < lo_w) begin
				dir_map = jq_pkg::DIR_BACK;
				ev_pct  = PB'(jq_pkg::FULL_SCALE);
			end else if (s_w > upper_w) begin
				dir_map = jq_pkg::DIR_FWD;
				ev_div  = 1'b1;
				num_w   = s_w - upper_w;
				den_w   = hi_w - upper_w;
			end else if (s_w < lower_w && s_w > lo_w) begin
				dir_map = jq_pkg::DIR_BACK;
				ev_div  = 1'b1;
				num_w   = lower_w - s_w;
				den_w   = lower_w - lo_w;
			end
		end

		ev_dir = dir_map;
		if (reverse_dir_q) begin
			case (dir_map)
				jq_pkg::DIR_FWD:  ev_dir = jq_pkg::DIR_BACK;
				jq_pkg::DIR_BACK: ev_dir = jq_pkg::DIR_FWD;
				default:          ev_dir = dir_map;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Restoring divider, one quotient bit per cycle, MSB first.
	// Numerator never exceeds the divisor on the mapped ranges, so the
	// quotient of num*100/den stays within 0..100 and fits PB bits.
	// ------------------------------------------------------------------
	logic [DW-1:0] rem_q, dsh_q;
	logic          ge;
	jq_pkg::dir_t   dir_q;
	jq_pkg::fault_t fault_q;

	assign ge = (rem_q >= dsh_q);

	always_ff @(posedge clk) begin
		case (state_q)
			jq_pkg::ST_EVAL: begin
				dir_q   <= ev_dir;
				fault_q <= ev_fault;
				pct_q   <= ev_pct;
				rem_q   <= DW'(num_w[ADC_BITS-1:0]) * DW'(jq_pkg::FULL_SCALE);
				dsh_q   <= DW'(den_w[ADC_BITS-1:0]) << (PB - 1);
				cnt_q   <= '0;
			end
			jq_pkg::ST_DIV: begin
				if (ge) rem_q <= rem_q - dsh_q;
				dsh_q <= dsh_q >> 1;
				pct_q <= {pct_q[PB-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (out_load)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			direction     <= dir_q;
			percent       <= pct_q;
			fault_code    <= fault_q;
			deadman_armed <= armed_q;
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_fault_stops: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (fault_code != jq_pkg::F_OK) |->
			(percent == '0) && (direction == jq_pkg::DIR_STOP))
		else $error("fault result not forced to stop");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (percent <= PB'(jq_pkg::FULL_SCALE)))
		else $error("percent above full scale");

	a_unarmed_neutral: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (fault_code == jq_pkg::F_OK) && !deadman_armed |->
			(direction == jq_pkg::DIR_STOP))
		else $error("motion without armed deadman");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == jq_pkg::ST_DIV) && (cnt_q == CNT_LAST) |=>
			(state_q == jq_pkg::ST_DONE))
		else $error("divider did not finish");

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;

	// Converter width used for the whole bench; the block is built with the same value.
	localparam int ADC_W   = 10;
	localparam int ADC_MAX = (1 << ADC_W) - 1;

	// Cycles to let pass once the last result is in: the full pipe plus margin.
	localparam int SETTLE = 16;

	// Index past the last register; writes there must be dropped.
	localparam int REG_UNMAPPED = 7;

	// Cap on printed mismatches so a broken build does not flood the log.
	localparam int REPORT_CAP = 60;

	typedef struct {
		jq_pkg::dir_t                dir;
		logic [jq_pkg::PCT_BITS-1:0] pct;
		jq_pkg::fault_t              fault;
		logic                        armed;
	} reading_t;

	// Calibration plans, one per phase of the run.
	typedef enum int {
		CAL_POWERON,
		CAL_EXTREME,
		CAL_RANDOM,
		CAL_NARROW,
		CAL_GARBAGE,
		CAL_SCRAMBLE,
		CAL_WIDE_BAND,
		CAL_INVERTED,
		CAL_NO_BAND,
		CAL_DEFAULTS
	} cal_plan_t;

	// Output-side stall patterns.
	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_RHYTHM,
		RX_HOLD
	} rx_mode_t;

	// Joystick predictor plus the queue of results still owed by the block.
	class jq_scoreboard;
		logic [ADC_W-1:0]            cal_low, cal_center, cal_high, band, lim_low, lim_high;
		logic                        swap_dir;
		logic                        armed;
		logic [jq_pkg::PCT_BITS-1:0] prev_pct;
		reading_t                    expected_q[$];
		int                          errors;
		int                          checked;

		function new();
			cal_low    = ADC_W'(jq_pkg::RST_ADC_LOW);
			cal_center = ADC_W'(jq_pkg::RST_MID_CODE);
			cal_high   = ADC_W'(jq_pkg::RST_ADC_HIGH);
			band       = ADC_W'(jq_pkg::RST_DEAD_BAND);
			lim_low    = ADC_W'(jq_pkg::RST_ALARM_LOW);
			lim_high   = ADC_W'(jq_pkg::RST_ALARM_HIGH);
			swap_dir   = 1'b0;
			armed      = 1'b0;
			prev_pct   = '0;
			errors     = 0;
			checked    = 0;
		endfunction

		function void write_reg(int r, logic [jq_pkg::DATA_BITS-1:0] data);
			case (r)
				jq_pkg::REG_ADC_LOW:     cal_low    = data[ADC_W-1:0];
				jq_pkg::REG_MID_CODE:    cal_center = data[ADC_W-1:0];
				jq_pkg::REG_ADC_HIGH:    cal_high   = data[ADC_W-1:0];
				jq_pkg::REG_DEAD_BAND:   band       = data[ADC_W-1:0];
				jq_pkg::REG_ALARM_LOW:   lim_low    = data[ADC_W-1:0];
				jq_pkg::REG_ALARM_HIGH:  lim_high   = data[ADC_W-1:0];
				jq_pkg::REG_REVERSE_DIR: swap_dir   = data[0];
				default: ;
			endcase
		endfunction

		function logic [jq_pkg::DATA_BITS-1:0] reg_value(int r);
			case (r)
				jq_pkg::REG_ADC_LOW:    return jq_pkg::DATA_BITS'(cal_low);
				jq_pkg::REG_MID_CODE:   return jq_pkg::DATA_BITS'(cal_center);
				jq_pkg::REG_ADC_HIGH:   return jq_pkg::DATA_BITS'(cal_high);
				jq_pkg::REG_DEAD_BAND:  return jq_pkg::DATA_BITS'(band);
				jq_pkg::REG_ALARM_LOW:  return jq_pkg::DATA_BITS'(lim_low);
				jq_pkg::REG_ALARM_HIGH: return jq_pkg::DATA_BITS'(lim_high);
				default:                return jq_pkg::DATA_BITS'(swap_dir);
			endcase
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction

		function void mismatch(string field, longint want, longint got);
			errors++;
			if (errors <= REPORT_CAP)
				$error("%s: expected %0d, got %0d", field, want, got);
		endfunction

		// Truncating percentage, guarded against a zero span, clamped at full scale.
		function logic [jq_pkg::PCT_BITS-1:0] pct_of(int num, int den);
			int q;
			q = (den == 0) ? 0 : (num * jq_pkg::FULL_SCALE) / den;
			if (q > jq_pkg::FULL_SCALE)
				q = jq_pkg::FULL_SCALE;
			return jq_pkg::PCT_BITS'(q);
		endfunction

		// Accepted input: advance the armed flag, rank faults, map the deflection.
		function void note_input(logic [ADC_W-1:0] s, logic held, logic eok);
			reading_t r;
			int v, lo, ce, hi, db, al, ah, upper, lower;
			v  = s;
			lo = cal_low;
			ce = cal_center;
			hi = cal_high;
			db = band;
			al = lim_low;
			ah = lim_high;

			if (held && prev_pct == 0)
				armed = 1'b1;
			else if (!held)
				armed = 1'b0;

			upper = ce + db;
			lower = (ce >= db) ? ce - db : 0;
			r.dir = jq_pkg::DIR_STOP;
			r.pct = '0;

			if (!eok)
				r.fault = jq_pkg::F_ESTOP;
			else if (!(ah > hi && hi > ce && ce > lo && lo > al) ||
					upper >= hi || lo + db >= ce)
				r.fault = jq_pkg::F_CAL;
			else if (v > ah || v < al)
				r.fault = jq_pkg::F_RANGE;
			else if (v == 0)
				r.fault = jq_pkg::F_ZERO;
			else if (!armed && (v > upper || v < lower))
				r.fault = jq_pkg::F_DEADMAN;
			else
				r.fault = jq_pkg::F_OK;

			if (r.fault == jq_pkg::F_OK) begin
				if (v > hi) begin
					r.dir = jq_pkg::DIR_FWD;
					r.pct = jq_pkg::PCT_BITS'(jq_pkg::FULL_SCALE);
				end else if (v < lo) begin
					r.dir = jq_pkg::DIR_BACK;
					r.pct = jq_pkg::PCT_BITS'(jq_pkg::FULL_SCALE);
				end else if (v > upper) begin
					r.dir = jq_pkg::DIR_FWD;
					r.pct = pct_of(v - upper, hi - upper);
				end else if (v < lower && v > lo) begin
					r.dir = jq_pkg::DIR_BACK;
					r.pct = pct_of(lower - v, lower - lo);
				end
				// stop stays stop under reversal
				if (swap_dir && r.dir != jq_pkg::DIR_STOP) begin
					if (r.dir == jq_pkg::DIR_FWD)
						r.dir = jq_pkg::DIR_BACK;
					else
						r.dir = jq_pkg::DIR_FWD;
				end
			end

			r.armed  = armed;
			prev_pct = r.pct;
			expected_q.push_back(r);
		endfunction

		function void check_result(logic [jq_pkg::DIR_BITS-1:0] dir,
				logic [jq_pkg::PCT_BITS-1:0] pct,
				logic [jq_pkg::FAULT_BITS-1:0] fault, logic arm);
			reading_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= REPORT_CAP)
					$error("unexpected result: direction %0d percent %0d fault %0d armed %0d",
						dir, pct, fault, arm);
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (dir !== want.dir)
				mismatch("direction", want.dir, dir);
			if (pct !== want.pct)
				mismatch("percent", want.pct, pct);
			if (fault !== want.fault)
				mismatch("fault_code", want.fault, fault);
			if (arm !== want.armed)
				mismatch("deadman_armed", want.armed, arm);
		endfunction
	endclass

	// ---------------------------------------------------------------- signals
	logic                          clk;
	logic                          arst_n;
	logic                          psel, penable, pwrite;
	logic [jq_pkg::ADDR_BITS-1:0]  paddr;
	logic [jq_pkg::DATA_BITS-1:0]  pwdata;
	logic [jq_pkg::DATA_BITS-1:0]  prdata;
	logic                          pready;
	logic                          in_valid, in_ready;
	logic [ADC_W-1:0]              sample;
	logic                          deadman_held, estop_ok;
	logic                          out_valid, out_ready;
	logic [jq_pkg::DIR_BITS-1:0]   direction;
	logic [jq_pkg::PCT_BITS-1:0]   percent;
	logic [jq_pkg::FAULT_BITS-1:0] fault_code;
	logic                          deadman_armed;

	jq_scoreboard sb;

	// Driver bookkeeping
	bit offering;      // in_valid is (or is about to be) high
	int burst_left;    // transactions left before the next gap
	bit hold_on;       // operator's deadman intent for the current stretch
	int hold_left;     // transactions left in that stretch
	int driven;
	int settings;

	string reg_names [7] = '{"adc_low", "mid_code", "adc_high", "dead_band",
		"alarm_low", "alarm_high", "reverse_dir"};

	// Directed transactions under power-on calibration
	// (low 100, center 512, high 900, band 20, alarms 20/1000):
	// {sample, deadman_held, estop_ok}
	logic [ADC_W+1:0] warmup [21] = '{
		{10'd512,  1'b0, 1'b0},   // estop outranks everything
		{10'd700,  1'b0, 1'b1},   // deflection without deadman
		{10'd0,    1'b1, 1'b1},   // below alarm_low; arms the flag
		{10'd1023, 1'b1, 1'b1},   // top code, above alarm_high
		{10'd19,   1'b1, 1'b1},   // one under alarm_low
		{10'd1001, 1'b1, 1'b1},   // one over alarm_high
		{10'd512,  1'b1, 1'b1},   // rest position
		{10'd533,  1'b1, 1'b1},   // first step past the band, rounds to 0
		{10'd716,  1'b1, 1'b1},   // mid forward
		{10'd900,  1'b1, 1'b1},   // exactly adc_high
		{10'd1000, 1'b1, 1'b1},   // beyond adc_high, at alarm_high
		{10'd901,  1'b0, 1'b1},   // release while deflected
		{10'd901,  1'b1, 1'b1},   // re-arm from 0%
		{10'd492,  1'b1, 1'b1},   // lower band edge
		{10'd491,  1'b1, 1'b1},   // first step below the band
		{10'd296,  1'b1, 1'b1},   // mid backward
		{10'd100,  1'b1, 1'b1},   // exactly adc_low: stop
		{10'd99,   1'b1, 1'b1},   // beyond adc_low
		{10'd20,   1'b1, 1'b1},   // at alarm_low
		{10'd300,  1'b1, 1'b0},   // estop while armed and deflected
		{10'd532,  1'b1, 1'b1}    // upper band edge
	};

	// Directed tail for the extreme calibration (alarm 0..1023, low 1, high 1022,
	// no band, reversed).
	logic [ADC_W+1:0] extreme_tail [4] = '{
		{10'd0,    1'b1, 1'b1},   // zero reading, only reachable with alarm_low 0
		{10'd1023, 1'b1, 1'b1},   // full forward, reported backward
		{10'd1,    1'b1, 1'b1},   // at adc_low
		{10'd511,  1'b1, 1'b1}    // small backward, reported forward
	};

	joystick_qualifier #(
		.ADC_BITS(ADC_W)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample       (sample),
		.deadman_held (deadman_held),
		.estop_ok     (estop_ok),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.direction    (direction),
		.percent      (percent),
		.fault_code   (fault_code),
		.deadman_armed(deadman_armed)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop for a hung block.
	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	// ---------------------------------------------------------------- config port
	// A setup phase, then an access phase; write lands and read data is taken at
	// the edge that closes the access phase.
	task automatic apb_xfer(bit wr, int r, logic [jq_pkg::DATA_BITS-1:0] wdata,
			output logic [jq_pkg::DATA_BITS-1:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= jq_pkg::ADDR_BITS'(r * 4);
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic reg_write(int r, logic [jq_pkg::DATA_BITS-1:0] data);
		logic [jq_pkg::DATA_BITS-1:0] unused;
		apb_xfer(1'b1, r, data, unused);
		sb.write_reg(r, data);
	endtask

	task automatic check_regs();
		logic [jq_pkg::DATA_BITS-1:0] got;
		for (int r = jq_pkg::REG_ADC_LOW; r <= jq_pkg::REG_REVERSE_DIR; r++) begin
			apb_xfer(1'b0, r, '0, got);
			if (got !== sb.reg_value(r))
				sb.mismatch(reg_names[r], sb.reg_value(r), got);
		end
	endtask

	// Build and write one calibration, then read it all back.
	task automatic load_cal(cal_plan_t plan);
		logic [jq_pkg::DATA_BITS-1:0] regv [7];
		int al, lo, db, ce, hi, ah, span, rev;
		bit narrow;
		narrow = (plan == CAL_NARROW);
		span   = narrow ? 3 : 250;
		rev    = $urandom_range(0, 1);
		// well-ordered calibration; narrow plans give spans of one to four codes
		do begin
			al = $urandom_range(0, narrow ? 1000 : 150);
			lo = al + 1 + $urandom_range(0, span);
			db = (plan == CAL_NO_BAND) ? 0 : $urandom_range(0, narrow ? 2 : 80);
			ce = lo + db + 1 + $urandom_range(0, span);
			hi = ce + db + 1 + $urandom_range(0, span);
			ah = hi + 1 + $urandom_range(0, span);
		end while (ah > ADC_MAX);

		case (plan)
			CAL_EXTREME: begin
				al = 0; lo = 1; db = 0; ce = 512; hi = ADC_MAX - 1; ah = ADC_MAX; rev = 1;
			end
			CAL_SCRAMBLE: begin
				al = $urandom_range(0, ADC_MAX);
				lo = $urandom_range(0, ADC_MAX);
				db = $urandom_range(0, ADC_MAX);
				ce = $urandom_range(0, ADC_MAX);
				hi = $urandom_range(0, ADC_MAX);
				ah = $urandom_range(0, ADC_MAX);
			end
			// band grows until it just touches an end point
			CAL_WIDE_BAND: db = (hi - ce < ce - lo) ? hi - ce : ce - lo;
			CAL_INVERTED: begin
				al = ADC_MAX; lo = 0; ce = 0; db = ADC_MAX; hi = ADC_MAX; ah = 0; rev = 1;
			end
			CAL_NO_BAND: rev = 0;
			CAL_DEFAULTS: begin
				al = jq_pkg::RST_ALARM_LOW; lo = jq_pkg::RST_ADC_LOW;
				db = jq_pkg::RST_DEAD_BAND; ce = jq_pkg::RST_MID_CODE;
				hi = jq_pkg::RST_ADC_HIGH; ah = jq_pkg::RST_ALARM_HIGH; rev = 0;
			end
			default: ;
		endcase

		regv[jq_pkg::REG_ADC_LOW]     = jq_pkg::DATA_BITS'(lo);
		regv[jq_pkg::REG_MID_CODE]    = jq_pkg::DATA_BITS'(ce);
		regv[jq_pkg::REG_ADC_HIGH]    = jq_pkg::DATA_BITS'(hi);
		regv[jq_pkg::REG_DEAD_BAND]   = jq_pkg::DATA_BITS'(db);
		regv[jq_pkg::REG_ALARM_LOW]   = jq_pkg::DATA_BITS'(al);
		regv[jq_pkg::REG_ALARM_HIGH]  = jq_pkg::DATA_BITS'(ah);
		regv[jq_pkg::REG_REVERSE_DIR] = jq_pkg::DATA_BITS'(rev);

		// noise above the stored bits must be dropped
		if (plan == CAL_GARBAGE) begin
			for (int r = jq_pkg::REG_ADC_LOW; r < jq_pkg::REG_REVERSE_DIR; r++)
				regv[r] = regv[r] | (jq_pkg::DATA_BITS'($urandom()) << ADC_W);
			regv[jq_pkg::REG_REVERSE_DIR] = regv[jq_pkg::REG_REVERSE_DIR] |
				(jq_pkg::DATA_BITS'($urandom()) & ~32'h1);
		end

		for (int r = jq_pkg::REG_ADC_LOW; r <= jq_pkg::REG_REVERSE_DIR; r++)
			reg_write(r, regv[r]);
		if (plan == CAL_GARBAGE)
			reg_write(REG_UNMAPPED, $urandom());
		check_regs();
	endtask

	// ---------------------------------------------------------------- input side
	// Gap insertion: bursts of random length and gaps between them, so idle cycles
	// land on every stage of the pipe; some bursts run long.
	task automatic pace();
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			offering = 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
	endtask

	// Called just after a rising edge; returns at the edge that took the transaction.
	task automatic send_item(logic [ADC_W-1:0] s, logic held, logic eok);
		in_valid     <= 1'b1;
		sample       <= s;
		deadman_held <= held;
		estop_ok     <= eok;
		offering = 1'b1;
		do @(posedge clk); while (in_ready !== 1'b1);
		sb.note_input(s, held, eok);
		driven++;
		pace();
	endtask

	// Readings cluster on calibration points and inside the alarm window, with
	// some full-range noise; every bit of the reading still toggles.
	function automatic logic [ADC_W-1:0] pick_sample();
		int marks [9];
		int ce, db, v, off;
		ce = sb.cal_center;
		db = sb.band;
		marks = '{int'(sb.lim_low), int'(sb.cal_low), (ce >= db) ? ce - db : 0, ce, ce + db,
			int'(sb.cal_high), int'(sb.lim_high), 0, ADC_MAX};
		off = $urandom_range(0, 4);
		case ($urandom_range(0, 5))
			0: v = $urandom_range(0, ADC_MAX);
			1, 2: v = marks[$urandom_range(0, 8)] + off - 2;
			default: v = (sb.lim_low <= sb.lim_high)
				? $urandom_range(sb.lim_low, sb.lim_high) : $urandom_range(0, ADC_MAX);
		endcase
		if (v < 0)
			v = 0;
		if (v > ADC_MAX)
			v = ADC_MAX;
		return ADC_W'(v);
	endfunction

	// Operator-like traffic: deadman held for long stretches (so the flag arms
	// and deflections get through), occasional glitches on it, rare estop.
	task automatic random_run(int n);
		logic held;
		for (int i = 0; i < n; i++) begin
			if (hold_left == 0) begin
				hold_on   = ($urandom_range(0, 4) != 0);
				hold_left = $urandom_range(1, 40);
			end
			hold_left--;
			held = hold_on ^ ($urandom_range(0, 29) == 0);
			send_item(pick_sample(), held, $urandom_range(0, 24) != 0);
		end
	endtask

	// Stop offering, let every owed result come out, then let the pipe settle.
	task automatic drain();
		if (offering) begin
			in_valid <= 1'b0;
			offering = 1'b0;
		end
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- output side
	// Stall patterns: always ready, coin flip, mostly stalled, fixed rhythm,
	// and a long hold-off that then opens.
	initial begin : sink
		rx_mode_t mode;
		int span;
		out_ready <= 1'b0;
		forever begin
			mode = rx_mode_t'($urandom_range(RX_OPEN, RX_HOLD));
			span = $urandom_range(10, 120);
			for (int c = 0; c < span; c++) begin
				@(posedge clk);
				case (mode)
					RX_OPEN:   out_ready <= 1'b1;
					RX_COIN:   out_ready <= $urandom_range(0, 1);
					RX_SPARSE: out_ready <= ($urandom_range(0, 5) == 0);
					RX_RHYTHM: out_ready <= (c % 3 != 2);
					default:   out_ready <= (c >= 30);
				endcase
			end
		end
	end

	// Result transactions are taken on the edge where valid and ready were both high.
	always @(posedge clk)
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
			sb.check_result(direction, percent, fault_code, deadman_armed);

	// ---------------------------------------------------------------- main sequence
	initial begin : stimulus
		cal_plan_t plan;
		sb = new();
		driven     = 0;
		settings   = 1;
		offering   = 1'b0;
		burst_left = $urandom_range(1, 12);
		hold_left  = 0;
		hold_on    = 1'b0;

		arst_n       <= 1'b0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		in_valid     <= 1'b0;
		sample       <= '0;
		deadman_held <= 1'b0;
		estop_ok     <= 1'b1;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// power-on calibration: reset values readable, directed corners, traffic
		check_regs();
		foreach (warmup[i])
			send_item(warmup[i][ADC_W+1:2], warmup[i][1], warmup[i][0]);
		random_run(180);

		// each new calibration goes in only after the block has fully drained
		for (int k = CAL_EXTREME; k <= CAL_DEFAULTS; k++) begin
			plan = cal_plan_t'(k);
			drain();
			load_cal(plan);
			settings++;
			if (plan == CAL_EXTREME)
				foreach (extreme_tail[i])
					send_item(extreme_tail[i][ADC_W+1:2], extreme_tail[i][1],
						extreme_tail[i][0]);
			// faulty calibrations only need a short look
			random_run((plan == CAL_SCRAMBLE || plan == CAL_WIDE_BAND ||
				plan == CAL_INVERTED) ? 60 : 205);
		end

		drain();

		$display("tb: %0d input transactions driven, %0d results checked field by field",
			driven, sb.checked);
		$display("tb: %0d calibrations, from power-on and extremes to misordered settings",
			settings);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[joystick_qualifier.f]
rtl/core/jq_pkg.sv
rtl/core/joystick_qualifier.sv
tb/tb.sv
